@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SIUR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define SIUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/siur_pkg.sv @@
`default_nettype none

package siur_pkg;

  localparam int PACKET_BYTES_DEF = 16;

  // Payload count field of a job; covers the largest packet size (64 - 8 bytes).
  localparam int NPAY_W = 6;

  localparam logic [31:0] MAX_LEN_RST = 32'd131064;

  localparam logic [7:0] SYNC0   = 8'hA5;
  localparam logic [7:0] SYNC1   = 8'h5A;
  localparam logic [7:0] CH_HASH = 8'h23;  // '#'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  typedef enum logic [1:0] {
    JOB_STAR,  // single '*'
    JOB_BANG,  // "!!!!*"
    JOB_ACK    // optional payload bytes, then '#' and 4 offset bytes
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [NPAY_W-1:0] npay;
    logic [31:0]       base;
    logic [31:0]       ack;
    logic              done;
  } job_t;

endpackage

`default_nettype wire

@@ sv/serial_image_update_receiver.sv @@
`default_nettype none

// Firmware image receiver for a byte link. Each input transfer is either a
// begin action (in_action = 0), answered with '*', or one received link byte
// (in_action = 1) that feeds the packet parser: packets open with A5 5A, the
// first one carries the image length, later ones a 16-bit halfword sum, a
// 32-bit offset and up to PACKET_BYTES-8 payload bytes. Every result transfer
// is either a byte to transmit (out_kind = 0, image offset zero) or an
// accepted payload byte with its image offset (out_kind = 1); out_last marks
// the final result caused by one input, and out_complete is set on all
// results of the packet that finishes the image. After completion further
// bytes are ignored until the next begin. cfg_max_image_len is the length
// limit, always ready; the user must write it only while the block is idle,
// which the block does not enforce. Timing: the parser takes one byte per
// cycle while in_stall is low. A packet end hands a job to a two-entry
// queue; the response unit drains it at one transmit byte per cycle unless
// out_stall holds it, and each payload byte first waits for its read from the
// payload buffer, which has a registered read port. in_stall rises only while
// two answers are still queued; at link byte rates it stays low.
module serial_image_update_receiver #(
  parameter int PACKET_BYTES = siur_pkg::PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_out_byte,
  output logic [31:0]      out_image_offset,
  output logic             out_last,
  output logic             out_complete,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_image_len
);

  // payload buffer: two banks, one per queue slot
  localparam int IW    = $clog2(PACKET_BYTES - 8);
  localparam int DEPTH = 2 << IW;

  logic           q_full, q_have, push, pop, wr_slot, rd_slot, ram_we;
  siur_pkg::job_t push_job, head;
  logic [IW:0]    ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  siur_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (in_valid && !in_stall),
    .in_action         (in_action),
    .in_rx_byte        (in_rx_byte),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_max_image_len (cfg_max_image_len),
    .wr_slot           (wr_slot),
    .push              (push),
    .job               (push_job),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata)
  );

  siur_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .have     (q_have),
    .head     (head),
    .wr_slot  (wr_slot),
    .rd_slot  (rd_slot)
  );

  siur_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  siur_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .have             (q_have),
    .head             (head),
    .rd_slot          (rd_slot),
    .ram_rdata        (ram_rdata),
    .out_stall        (out_stall),
    .pop              (pop),
    .ram_raddr        (ram_raddr),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_out_byte     (out_out_byte),
    .out_image_offset (out_image_offset),
    .out_last         (out_last),
    .out_complete     (out_complete)
  );

endmodule

`default_nettype wire

@@ sv/siur_ram.sv @@
`default_nettype none

module siur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/siur_front.sv @@
`default_nettype none

module siur_front #(
  parameter int PACKET_BYTES = siur_pkg::PACKET_BYTES_DEF,
  localparam int BW = $clog2(PACKET_BYTES + 1),
  localparam int IW = $clog2(PACKET_BYTES - 8)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic           in_action,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_max_image_len,
  input  wire logic           wr_slot,
  output logic                push,
  output siur_pkg::job_t      job,
  output logic                ram_we,
  output logic [IW:0]         ram_waddr,
  output logic [7:0]          ram_wdata
);

  typedef enum logic [1:0] {PH_IDLE, PH_RECV, PH_DONE} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [31:0]   exp_r, exp_nxt;
  logic [31:0]   field_r, field_nxt;
  logic [15:0]   sent_r, sent_nxt;
  logic [15:0]   run_r, run_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [31:0]   max_r;

  logic [BW-1:0] cnt_inc, psize, pofs;
  logic [31:0]   psize32, sum_off, field_n;
  logic [15:0]   sent_n, run_n;
  logic [7:0]    pend_n;
  logic          pkt_end, match, done;

  assign cnt_inc = cnt_r + 1'b1;
  assign psize   = cnt_inc - BW'(8);
  assign pofs    = cnt_r - BW'(8);
  assign psize32 = 32'(psize);
  assign sum_off = exp_r + psize32;

  assign ram_wdata = in_rx_byte;
  assign ram_waddr = {wr_slot, pofs[IW-1:0]};

  always_comb begin
    // field bytes 2..7 shift in from the top, little-endian
    field_n = (cnt_r < BW'(8)) ? {in_rx_byte, field_r[31:8]} : field_r;
    sent_n  = sent_r;
    run_n   = run_r;
    pend_n  = pend_r;
    if (cnt_r == BW'(2)) begin
      sent_n = {8'h00, in_rx_byte};
    end else if (cnt_r == BW'(3)) begin
      sent_n = {in_rx_byte, sent_r[7:0]};
    end else if (!cnt_r[0]) begin
      pend_n = in_rx_byte;
    end else begin
      run_n = run_r + {in_rx_byte, pend_r};
    end
  end

  assign pkt_end = ((cnt_inc > BW'(8)) && (total_r <= sum_off)) ||
                   (cnt_inc >= BW'(PACKET_BYTES));
  assign match   = (field_n == exp_r);
  assign done    = match ? (sum_off >= total_r) : (exp_r >= total_r);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    exp_nxt   = exp_r;
    field_nxt = field_r;
    sent_nxt  = sent_r;
    run_nxt   = run_r;
    pend_nxt  = pend_r;
    push      = 1'b0;
    job       = '0;
    job.kind  = siur_pkg::JOB_STAR;
    ram_we    = 1'b0;

    if (acc) begin
      if (!in_action) begin
        phase_nxt = PH_RECV;
        total_nxt = '0;
        exp_nxt   = '0;
        cnt_nxt   = '0;
        field_nxt = '0;
        sent_nxt  = '0;
        run_nxt   = '0;
        pend_nxt  = '0;
        push      = 1'b1;
      end else if (phase_r == PH_RECV) begin
        if (cnt_r == '0) begin
          pend_nxt = in_rx_byte;
          cnt_nxt  = BW'(1);
        end else if (cnt_r == BW'(1)) begin
          cnt_nxt   = (pend_r == siur_pkg::SYNC0 && in_rx_byte == siur_pkg::SYNC1) ?
                      BW'(2) : '0;
          field_nxt = '0;
          sent_nxt  = '0;
          run_nxt   = '0;
          pend_nxt  = '0;
        end else begin
          ram_we    = (cnt_r >= BW'(8));
          cnt_nxt   = cnt_inc;
          field_nxt = field_n;
          sent_nxt  = sent_n;
          run_nxt   = run_n;
          pend_nxt  = pend_n;
          if (total_r == '0) begin
            // length packet
            if (cnt_inc == BW'(6) || cnt_inc >= BW'(PACKET_BYTES)) begin
              push = 1'b1;
              if (field_n > max_r) begin
                job.kind = siur_pkg::JOB_BANG;
              end else begin
                job.kind  = siur_pkg::JOB_ACK;
                total_nxt = field_n;
              end
              cnt_nxt   = '0;
              field_nxt = '0;
              sent_nxt  = '0;
              run_nxt   = '0;
              pend_nxt  = '0;
            end
          end else if (pkt_end) begin
            push     = 1'b1;
            job.kind = siur_pkg::JOB_ACK;
            job.base = exp_r;
            job.ack  = exp_r;
            if (run_n == sent_n) begin
              if (match) begin
                job.npay = siur_pkg::NPAY_W'(psize);
                job.ack  = sum_off;
                exp_nxt  = sum_off;
              end
              job.done = done;
              if (done) begin
                phase_nxt = PH_DONE;
              end
            end
            cnt_nxt   = '0;
            field_nxt = '0;
            sent_nxt  = '0;
            run_nxt   = '0;
            pend_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
      exp_r   <= '0;
      field_r <= '0;
      sent_r  <= '0;
      run_r   <= '0;
      pend_r  <= '0;
      max_r   <= siur_pkg::MAX_LEN_RST;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      exp_r   <= exp_nxt;
      field_r <= field_nxt;
      sent_r  <= sent_nxt;
      run_r   <= run_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        max_r <= cfg_max_image_len;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/siur_queue.sv @@
`default_nettype none

module siur_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire siur_pkg::job_t  push_job,
  input  wire logic            pop,
  output logic                 full,
  output logic                 have,
  output siur_pkg::job_t       head,
  output logic                 wr_slot,
  output logic                 rd_slot
);

  // two entries; slot number doubles as the payload bank select
  localparam logic [1:0] CNT_FULL = 2'd2;

  siur_pkg::job_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign full    = (cnt_r == CNT_FULL);
  assign have    = (cnt_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign wr_slot = wr_ptr_r;
  assign rd_slot = rd_ptr_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ sv/siur_back.sv @@
`default_nettype none

module siur_back #(
  parameter int PACKET_BYTES = siur_pkg::PACKET_BYTES_DEF,
  localparam int IW = $clog2(PACKET_BYTES - 8)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            have,
  input  wire siur_pkg::job_t  head,
  input  wire logic            rd_slot,
  input  wire logic [7:0]      ram_rdata,
  input  wire logic            out_stall,
  output logic                 pop,
  output logic [IW:0]          ram_raddr,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [7:0]           out_out_byte,
  output logic [31:0]          out_image_offset,
  output logic                 out_last,
  output logic                 out_complete
);

  logic [siur_pkg::NPAY_W-1:0] pay_r;
  logic [2:0]                  tail_r;
  logic                        dok_r;
  logic                        out_valid_r, out_kind_r, out_last_r, out_complete_r;
  logic [7:0]                  out_byte_r;
  logic [31:0]                 out_off_r;

  logic       in_pay, free, fire, last;
  logic [2:0] tail_end;
  logic [7:0] tx_byte;

  assign in_pay    = (pay_r < head.npay);
  assign tail_end  = (head.kind == siur_pkg::JOB_STAR) ? 3'd0 : 3'd4;
  assign last      = !in_pay && (tail_r == tail_end);
  assign free      = !out_valid_r || !out_stall;
  // payload read data is good in the cycle after the address settles
  assign fire      = have && free && (!in_pay || dok_r);
  assign pop       = fire && last;
  assign ram_raddr = {rd_slot, pay_r[IW-1:0]};

  always_comb begin
    case (head.kind)
      siur_pkg::JOB_STAR: tx_byte = siur_pkg::CH_STAR;
      siur_pkg::JOB_BANG: tx_byte = (tail_r == 3'd4) ? siur_pkg::CH_STAR : siur_pkg::CH_BANG;
      siur_pkg::JOB_ACK: begin
        case (tail_r)
          3'd0:    tx_byte = siur_pkg::CH_HASH;
          3'd1:    tx_byte = head.ack[7:0];
          3'd2:    tx_byte = head.ack[15:8];
          3'd3:    tx_byte = head.ack[23:16];
          default: tx_byte = head.ack[31:24];
        endcase
      end
      default:            tx_byte = siur_pkg::CH_STAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pay_r       <= '0;
      tail_r      <= '0;
      dok_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dok_r <= have && !(fire && (in_pay || last));
      if (fire) begin
        out_valid_r <= 1'b1;
        if (in_pay) begin
          pay_r <= pay_r + 1'b1;
        end else if (last) begin
          pay_r  <= '0;
          tail_r <= '0;
        end else begin
          tail_r <= tail_r + 1'b1;
        end
      end else if (free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_complete_r <= head.done;
      out_last_r     <= last;
      if (in_pay) begin
        out_kind_r <= siur_pkg::KIND_PAY;
        out_byte_r <= ram_rdata;
        out_off_r  <= head.base + 32'(pay_r);
      end else begin
        out_kind_r <= siur_pkg::KIND_TX;
        out_byte_r <= tx_byte;
        out_off_r  <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_out_byte     = out_byte_r;
  assign out_image_offset = out_off_r;
  assign out_last         = out_last_r;
  assign out_complete     = out_complete_r;

endmodule

`default_nettype wire

@@ sv/siur_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module siur_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [7:0]  out_out_byte,
  input wire logic [31:0] out_image_offset,
  input wire logic        out_last
);

  // result payload that must hold while stalled
  logic [41:0] out_pl;

  assign out_pl = {out_kind, out_out_byte, out_image_offset, out_last};

  `SIUR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pl))
  `SIUR_ASSERT_IMPLY(a_quiet_after_reset, clk, rst_n, $past(!rst_n), !out_valid)
  `SIUR_ASSERT_IMPLY(a_payload_not_last, clk, rst_n, out_valid && out_kind, !out_last)
  `SIUR_ASSERT_IMPLY(a_tx_zero_offset, clk, rst_n, out_valid && !out_kind, out_image_offset == '0)

endmodule

bind serial_image_update_receiver siur_checker u_siur_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_out_byte     (out_out_byte),
  .out_image_offset (out_image_offset),
  .out_last         (out_last)
);

`default_nettype wire

@@ tb/serial_image_update_receiver_tb.sv @@
module serial_image_update_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT_BYTES = siur_pkg::PACKET_BYTES_DEF;
  localparam int PAY_MAX = PKT_BYTES - 8;
  // Longest answer drain of the response unit, doubled, plus margin.
  localparam int SETTLE_CYCLES = 2 * (2 * PAY_MAX + 5) + 10;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    SESS_IDLE,  // no begin seen yet
    SESS_RECV,  // session open, parsing packets
    SESS_DONE   // image complete, link bytes ignored
  } sess_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  val;
    logic [31:0] offset;
    logic        last;
    logic        complete;
  } link_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [7:0]  out_out_byte;
  logic [31:0] out_image_offset;
  logic        out_last;
  logic        out_complete;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_max_image_len;

  serial_image_update_receiver #(
    .PACKET_BYTES(PKT_BYTES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_out_byte     (out_out_byte),
    .out_image_offset (out_image_offset),
    .out_last         (out_last),
    .out_complete     (out_complete),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_image_len(cfg_max_image_len)
  );

  // ---------------------------------------------------------------------------
  // Receiver state as the testbench sees it. Updated once per accepted input
  // transfer; the stimulus side also reads it to build well-formed packets.
  // ---------------------------------------------------------------------------
  sess_t       sess;
  logic [31:0] max_len;    // length limit currently programmed
  logic [31:0] tot_len;    // 0 while the length packet is still awaited
  logic [31:0] exp_off;    // next image offset the receiver will take
  logic [31:0] fld;        // length/offset bytes, shifted in from the top
  logic [4:0]  pkt_cnt;    // bytes of the current packet
  logic [15:0] sent_sum;
  logic [15:0] run_sum;
  logic [7:0]  pend_lo;    // first sync byte or low byte of a halfword
  logic [7:0]  pay_buf [PAY_MAX];

  link_rsp_t pending_replies[$];  // expected result transfers, oldest first
  link_rsp_t step_replies[$];     // results of the transfer being predicted

  int err_cnt;
  int live_items;       // input transfers the receiver does not ignore
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_packet();
    pkt_cnt  = '0;
    fld      = '0;
    sent_sum = '0;
    run_sum  = '0;
    pend_lo  = '0;
  endfunction

  function automatic void stage_reply(logic kind, logic [7:0] val, logic [31:0] off);
    link_rsp_t r;
    r.kind     = kind;
    r.val      = val;
    r.offset   = off;
    r.last     = 1'b0;
    r.complete = 1'b0;
    step_replies.push_back(r);
  endfunction

  // '#' then the next offset, little endian
  function automatic void stage_ack(logic [31:0] v);
    stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_HASH, 32'd0);
    stage_reply(siur_pkg::KIND_TX, v[7:0], 32'd0);
    stage_reply(siur_pkg::KIND_TX, v[15:8], 32'd0);
    stage_reply(siur_pkg::KIND_TX, v[23:16], 32'd0);
    stage_reply(siur_pkg::KIND_TX, v[31:24], 32'd0);
  endfunction

  function automatic void advance_receiver(logic act, logic [7:0] b);
    logic [4:0]  idx;
    logic [31:0] n_pay;
    logic        done;
    link_rsp_t   r;
    done = 1'b0;
    step_replies.delete();
    if (act == ACT_BEGIN || sess == SESS_RECV) live_items++;

    if (act == ACT_BEGIN) begin
      // begin restarts everything, whatever the parser was doing
      sess    = SESS_RECV;
      tot_len = '0;
      exp_off = '0;
      clear_packet();
      stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_STAR, 32'd0);
    end else if (sess == SESS_RECV) begin
      idx = pkt_cnt;
      if (idx == 0) begin
        pend_lo = b;
        pkt_cnt = 5'd1;
      end else if (idx == 1) begin
        // the pair is consumed either way; only A5 5A opens a packet
        if (pend_lo == siur_pkg::SYNC0 && b == siur_pkg::SYNC1) begin
          clear_packet();
          pkt_cnt = 5'd2;
        end else begin
          clear_packet();
        end
      end else begin
        if (idx < 8) fld = {b, fld[31:8]};
        // offset halfwords count in the sum; bytes 2..3 are the sum itself
        if (idx == 2) sent_sum = {8'h00, b};
        else if (idx == 3) sent_sum[15:8] = b;
        else if (!idx[0]) pend_lo = b;
        else run_sum = run_sum + {b, pend_lo};
        if (idx >= 8 && idx < PKT_BYTES) pay_buf[idx - 8] = b;
        pkt_cnt = idx + 5'd1;

        if (tot_len == 0) begin
          // length packet: ends after the four length bytes
          if (pkt_cnt == 6 || pkt_cnt >= PKT_BYTES) begin
            if (fld > max_len) begin
              stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_BANG, 32'd0);
              stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_BANG, 32'd0);
              stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_BANG, 32'd0);
              stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_BANG, 32'd0);
              stage_reply(siur_pkg::KIND_TX, siur_pkg::CH_STAR, 32'd0);
            end else begin
              tot_len = fld;
              stage_ack(32'd0);
            end
            clear_packet();
          end
        end else if ((pkt_cnt > 8 && tot_len <= {27'd0, pkt_cnt} - 32'd8 + exp_off) ||
                     pkt_cnt >= PKT_BYTES) begin
          // data packet end: full, or reached the image end
          if (run_sum != sent_sum) begin
            stage_ack(exp_off);
          end else begin
            if (fld == exp_off) begin
              n_pay = {27'd0, pkt_cnt} - 32'd8;
              for (int k = 0; k < n_pay; k++)
                stage_reply(siur_pkg::KIND_PAY, pay_buf[k], exp_off + 32'(k));
              exp_off = exp_off + n_pay;
            end
            stage_ack(exp_off);
            if (exp_off >= tot_len) begin
              done = 1'b1;
              sess = SESS_DONE;
            end
          end
          clear_packet();
        end
      end
    end

    if (step_replies.size() > 0) begin
      step_replies[step_replies.size() - 1].last = 1'b1;
      foreach (step_replies[k]) begin
        r = step_replies[k];
        r.complete = done;
        pending_replies.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge, handshakes are sampled on the
  // rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_transfer(input logic act, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    advance_receiver(act, b);
  endtask

  task automatic send_link_byte(input logic [7:0] b);
    send_transfer(ACT_BYTE, b);
  endtask

  // rx_byte is don't-care on a begin; keep it moving anyway
  task automatic send_begin();
    send_transfer(ACT_BEGIN, 8'($urandom));
  endtask

  task automatic send_length_packet(input logic [31:0] len);
    send_link_byte(siur_pkg::SYNC0);
    send_link_byte(siur_pkg::SYNC1);
    send_link_byte(len[7:0]);
    send_link_byte(len[15:8]);
    send_link_byte(len[23:16]);
    send_link_byte(len[31:24]);
  endtask

  // Data packet sized for the current expected offset (short at the image end).
  // fill < 0 gives random payload; cut > 0 stops after that many bytes.
  task automatic send_data_packet(input logic [31:0] off, input logic bad_sum,
                                  input int cut, input int fill);
    logic [7:0]  pkt [PKT_BYTES];
    logic [15:0] sum;
    logic [31:0] remain;
    int          n_pay;
    int          n_bytes;
    remain  = tot_len - exp_off;
    n_pay   = (remain < 32'(PAY_MAX)) ? int'(remain) : PAY_MAX;
    n_bytes = 8 + n_pay;
    pkt[0]  = siur_pkg::SYNC0;
    pkt[1]  = siur_pkg::SYNC1;
    pkt[4]  = off[7:0];
    pkt[5]  = off[15:8];
    pkt[6]  = off[23:16];
    pkt[7]  = off[31:24];
    for (int k = 0; k < n_pay; k++)
      pkt[8 + k] = (fill < 0) ? 8'($urandom) : 8'(fill);
    // halfword sum from the offset on; an odd trailing byte is left out
    sum = '0;
    for (int j = 4; j + 1 < n_bytes; j += 2)
      sum = sum + {pkt[j + 1], pkt[j]};
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    pkt[2] = sum[7:0];
    pkt[3] = sum[15:8];
    if (cut > 0 && cut < n_bytes) n_bytes = cut;
    for (int k = 0; k < n_bytes; k++)
      send_link_byte(pkt[k]);
  endtask

  // Two bytes that never form A5 5A; the parser drops them as a pair.
  task automatic send_noise_pair();
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    if (b0 == siur_pkg::SYNC0 && b1 == siur_pkg::SYNC1) b1 = 8'h00;
    send_link_byte(b0);
    send_link_byte(b1);
  endtask

  // Close a dangling half pair so the next packet starts on a pair boundary.
  task automatic realign();
    if (sess == SESS_RECV && pkt_cnt == 1) send_link_byte(8'h00);
  endtask

  // Drop valid, let every expected result drain, then give the response unit
  // time to go quiet.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_max_image_len <= v;
    do @(posedge clk); while (!cfg_ready);
    max_len = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and the checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic report_mismatch(input string what, input link_rsp_t got,
                                 input link_rsp_t want);
    err_cnt++;
    $display("%0t %s: got k%0d %02h @%08h l%0d c%0d, want k%0d %02h @%08h l%0d c%0d",
             $time, what, got.kind, got.val, got.offset, got.last, got.complete,
             want.kind, want.val, want.offset, want.last, want.complete);
  endtask

  always @(posedge clk) begin : check_replies
    link_rsp_t got;
    link_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind     = out_kind;
      got.val      = out_out_byte;
      got.offset   = out_image_offset;
      got.last     = out_last;
      got.complete = out_complete;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) report_mismatch("result mismatch", got, want);
      end
    end
  end

  // Hang detection: the run fails once quiet_cycles reaches STALL_LIMIT.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Link bytes before any begin produce nothing.
  task automatic test_link_before_begin();
    send_link_byte(siur_pkg::SYNC0);
    send_link_byte(8'h00);
  endtask

  // Begin, a reversed sync pair, then the length packet cases: over the reset
  // limit, zero (acked, length still awaited) and a one-byte image.
  task automatic test_length_packet();
    send_begin();
    send_link_byte(siur_pkg::SYNC1);
    send_link_byte(siur_pkg::SYNC0);
    send_length_packet(siur_pkg::MAX_LEN_RST + 32'd1);
    send_length_packet(32'd0);
    send_length_packet(32'd1);
  endtask

  // One-byte image, so each packet has a single unpaired payload byte:
  // bad sum, good sum at the wrong offset, then the good one that completes.
  task automatic test_data_packet();
    send_data_packet(32'd0, 1'b1, 0, 8'h00);
    send_data_packet(32'hFFFF_FFFF, 1'b0, 0, 8'hFF);
    send_data_packet(32'd0, 1'b0, 0, 8'hFF);
  endtask

  // Bytes after completion are dropped; begin restarts, also mid-packet.
  task automatic test_after_complete();
    send_link_byte(8'hFF);
    send_link_byte(siur_pkg::SYNC0);
    send_begin();
    send_link_byte(siur_pkg::SYNC0);
    send_link_byte(siur_pkg::SYNC1);
    send_link_byte(8'h10);
    send_begin();
  endtask

  // Limit at both ends: zero rejects any nonzero length, all-ones takes the
  // largest one and a full-size data packet follows.
  task automatic test_length_limit_extremes();
    write_max_len(32'd0);
    send_begin();
    send_length_packet(32'd1);
    send_length_packet(32'd0);
    write_max_len(32'hFFFF_FFFF);
    send_begin();
    send_length_packet(32'hFFFF_FFFF);
    send_data_packet(32'd0, 1'b0, 0, -1);
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 32'd0;
    if (r == 1 && max_len != 32'hFFFF_FFFF) return max_len + 32'd1;
    if (r == 2 && max_len <= 40) return max_len;
    return 32'($urandom_range(1, 24));
  endfunction

  // One session: begin, length packet, then data packets that are mostly
  // good with some bad sums, wrong offsets, noise and a truncated packet.
  task automatic run_session();
    int tries;
    int pkts;
    int pick;
    send_begin();
    if ($urandom_range(7) == 0) send_noise_pair();
    tries = 0;
    while (sess == SESS_RECV && tot_len == 0 && tries < 3) begin
      realign();
      send_length_packet(pick_length());
      tries++;
    end
    pkts = 0;
    while (sess == SESS_RECV && tot_len != 0 && pkts < 6) begin
      realign();
      pick = $urandom_range(15);
      pkts++;
      case (pick)
        0: send_data_packet(exp_off, 1'b1, 0, -1);
        1: send_data_packet(exp_off ^ (32'd1 << $urandom_range(31)), 1'b0, 0, -1);
        2: begin
          // broken packet; the next session's begin cleans up
          send_data_packet(exp_off, 1'b0, $urandom_range(2, 8), -1);
          return;
        end
        3: begin
          send_noise_pair();
          send_data_packet(exp_off, 1'b0, 0, -1);
        end
        default: send_data_packet(exp_off, 1'b0, 0, -1);
      endcase
    end
    if (sess == SESS_DONE && $urandom_range(1) == 1) send_link_byte(8'($urandom));
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input logic [31:0] limit, input int n_items);
    int target;
    write_max_len(limit);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = live_items + n_items;
    while (live_items < target) run_session();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_BEGIN;
    in_rx_byte        = 8'h00;
    out_stall         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_max_image_len = '0;
    err_cnt           = 0;
    live_items        = 0;
    quiet_cycles      = 0;
    send_idle_pct     = 18;
    recv_idle_pct     = 85;

    sess    = SESS_IDLE;
    max_len = siur_pkg::MAX_LEN_RST;
    tot_len = '0;
    exp_off = '0;
    clear_packet();
    foreach (pay_buf[k]) pay_buf[k] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_link_before_begin();
    test_length_packet();
    test_data_packet();
    test_after_complete();
    test_length_limit_extremes();
    test_random_traffic(18, 85, 32'($urandom_range(12, 40)), 6);
    test_random_traffic(85, 18, siur_pkg::MAX_LEN_RST, 6);
    test_random_traffic(0, 0, 32'($urandom_range(1, 24)), 6);

    wait_idle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ serial_image_update_receiver.f @@
+incdir+sv
sv/siur_pkg.sv
sv/siur_ram.sv
sv/siur_front.sv
sv/siur_queue.sv
sv/siur_back.sv
sv/serial_image_update_receiver.sv
sv/siur_checker.sv
tb/serial_image_update_receiver_tb.sv
